>>> hw/rtl/jos_pkg.sv
// shared constants, types and state codes of the josephus survivor block
package jos_pkg;

  localparam int MAX_PEOPLE = 1024;
  localparam int IDX_W      = $clog2(MAX_PEOPLE);
  localparam int PEOPLE_W   = 11;
  localparam int STEP_W     = 16;
  localparam int ITER_W     = $clog2(STEP_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD,
    ST_CHECK,
    ST_DIV,
    ST_WALK_RD,
    ST_WALK_WAIT,
    ST_UNLINK_RD,
    ST_UNLINK_WR,
    ST_FINISH
  } jos_state_t;

  typedef struct packed {
    logic                done;
    logic [PEOPLE_W-1:0] value;
  } rem_res_t;

endpackage

>>> hw/rtl/josephus_survivor_top.sv
// josephus survivor: ring walk over a successor memory with serial remainder
// One request at a time. The ring of n people (count clamped to 1..1024) is
// written into a 1024-entry successor memory, one entry per cycle. Each of
// the n-1 eliminations then runs one check step, a wait on the serial
// remainder unit for k = (m-1) mod r, where r is the number of people still
// in the ring, a read and a wait state for each of the k links followed
// through the single-port-read memory, and a read and a write to unlink. The
// finished result sits in an output register, so the next request can be
// taken while it waits for its transfer.
module josephus_survivor_top import jos_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PEOPLE_W-1:0] people_count,
  input  logic [STEP_W-1:0]   step_size,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PEOPLE_W-1:0] survivor
);

  jos_state_t          state;
  jos_state_t          state_next;

  logic [PEOPLE_W-1:0] count_reg;
  logic [STEP_W-1:0]   advance;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    last_idx;
  logic [IDX_W-1:0]    cur;
  logic [IDX_W-1:0]    prev;
  logic [PEOPLE_W-1:0] remaining;
  logic [PEOPLE_W-1:0] walk_k;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [IDX_W-1:0]    mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;
  logic [IDX_W-1:0]    mem_rdata;
  logic [IDX_W-1:0]    succ_mem [MAX_PEOPLE];

  logic                div_start;
  rem_res_t            div_res;
  logic                out_load;

  logic [PEOPLE_W-1:0] count_clamped;
  logic [PEOPLE_W-1:0] count_m1;

  always_comb begin
    if (people_count == '0) begin
      count_clamped = PEOPLE_W'(1);
    end else if (people_count > PEOPLE_W'(MAX_PEOPLE)) begin
      count_clamped = PEOPLE_W'(MAX_PEOPLE);
    end else begin
      count_clamped = people_count;
    end
  end

  assign count_m1 = count_reg - PEOPLE_W'(1);
  assign last_idx = count_m1[IDX_W-1:0];
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ready);

  jos_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (advance),
    .divisor  (remaining),
    .res      (div_res)
  );

  // successor memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      succ_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= succ_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_BUILD;
        end
      end
      ST_BUILD: begin
        if (idx == last_idx) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (remaining == PEOPLE_W'(1)) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          if (div_res.value == '0) begin
            state_next = ST_UNLINK_RD;
          end else begin
            state_next = ST_WALK_RD;
          end
        end
      end
      ST_WALK_RD: begin
        state_next = ST_WALK_WAIT;
      end
      ST_WALK_WAIT: begin
        if (walk_k == PEOPLE_W'(1)) begin
          state_next = ST_UNLINK_RD;
        end else begin
          state_next = ST_WALK_RD;
        end
      end
      ST_UNLINK_RD: begin
        state_next = ST_UNLINK_WR;
      end
      ST_UNLINK_WR: begin
        state_next = ST_CHECK;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '0;
    mem_raddr = cur;
    div_start = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_BUILD: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = (idx == last_idx) ? '0 : idx + IDX_W'(1);
      end
      ST_CHECK: begin
        div_start = (remaining != PEOPLE_W'(1));
      end
      ST_UNLINK_WR: begin
        mem_we    = 1'b1;
        mem_waddr = prev;
        mem_wdata = mem_rdata;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          count_reg <= count_clamped;
          advance   <= (step_size == '0) ? '0 : step_size - STEP_W'(1);
          idx       <= '0;
        end
      end
      ST_BUILD: begin
        idx <= idx + IDX_W'(1);
        if (idx == last_idx) begin
          cur       <= '0;
          prev      <= last_idx;
          remaining <= count_reg;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          walk_k <= div_res.value;
        end
      end
      ST_WALK_WAIT: begin
        prev   <= cur;
        cur    <= mem_rdata;
        walk_k <= walk_k - PEOPLE_W'(1);
      end
      ST_UNLINK_WR: begin
        cur       <= mem_rdata;
        remaining <= remaining - PEOPLE_W'(1);
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      survivor <= {1'b0, cur} + PEOPLE_W'(1);
    end
  end

  a_div_needs_two: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> remaining > PEOPLE_W'(1))
    else $error("remainder taken over a ring of fewer than two");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_res.done) |-> div_res.value < remaining)
    else $error("walk length not below ring size");

  a_walk_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK_RD |-> walk_k != '0)
    else $error("walk step with no links left");

  a_unlink_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == ST_UNLINK_WR |=> remaining == $past(remaining) - PEOPLE_W'(1))
    else $error("unlink did not shrink the ring by one");

  a_survivor_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> survivor != '0)
    else $error("survivor number zero");

endmodule

>>> hw/rtl/jos_rem_unit.sv
// bit-serial remainder unit: one quotient bit per cycle
module jos_rem_unit import jos_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [STEP_W-1:0]   dividend,
  input  logic [PEOPLE_W-1:0] divisor,
  output rem_res_t            res
);

  logic                busy;
  logic                done;
  logic [ITER_W-1:0]   iter;
  logic [STEP_W-1:0]   shreg;
  logic [PEOPLE_W-1:0] part;
  logic [PEOPLE_W-1:0] dvs;
  logic [PEOPLE_W:0]   trial;
  logic [PEOPLE_W:0]   diff;

  assign trial = {part, shreg[STEP_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + ITER_W'(1);
        if (iter == ITER_W'(STEP_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      part  <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      shreg <= {shreg[STEP_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        part <= diff[PEOPLE_W-1:0];
      end else begin
        part <= trial[PEOPLE_W-1:0];
      end
    end
  end

  assign res.done  = done;
  assign res.value = part;

endmodule

>>> tb/testbench.sv
// testbench for josephus_survivor_top: predicted survivors checked per transfer
`timescale 1ns / 1ps

module testbench;
  import jos_pkg::*;

  localparam int CYCLE_LIMIT = 30000000;
  localparam int DRAIN_SLACK = 300;
  localparam int HOLD_CYCLES = 4000;

  class survivor_board;
    logic [PEOPLE_W-1:0] expected_survivors[$];
    int requests;
    int survivors_seen;
    int mismatches;

    function logic [PEOPLE_W-1:0] josephus_last(logic [PEOPLE_W-1:0] cnt,
                                                logic [STEP_W-1:0] stp);
      int unsigned ring_size;
      int unsigned hop;
      int unsigned pos;
      ring_size = (cnt == 0) ? 1 : ((cnt > MAX_PEOPLE) ? MAX_PEOPLE : cnt);
      hop = (stp == 0) ? 0 : stp - 1;
      pos = 0;
      // survivor index grows back one ring size at a time
      for (int unsigned r = 2; r <= ring_size; r++) begin
        pos = (pos + hop + 1) % r;
      end
      return PEOPLE_W'(pos + 1);
    endfunction

    function void note_request(logic [PEOPLE_W-1:0] cnt, logic [STEP_W-1:0] stp);
      expected_survivors.push_back(josephus_last(cnt, stp));
      requests++;
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic [PEOPLE_W-1:0] got);
      logic [PEOPLE_W-1:0] want;
      survivors_seen++;
      if (expected_survivors.size() == 0) begin
        report($sformatf("survivor %0d with no request waiting", got));
      end else begin
        want = expected_survivors.pop_front();
        if (got !== want)
          report($sformatf("survivor %0d, expected %0d", got, want));
      end
    endtask

    function int pending();
      return expected_survivors.size();
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [PEOPLE_W-1:0] people_count = '0;
  logic [STEP_W-1:0]   step_size = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PEOPLE_W-1:0] survivor;

  survivor_board board;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;

  josephus_survivor_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .people_count(people_count),
    .step_size(step_size),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .survivor(survivor)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("josephus_survivor_top test failed");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result(survivor);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(input logic [PEOPLE_W-1:0] cnt,
                              input logic [STEP_W-1:0] stp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    people_count <= cnt;
    step_size <= stp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(cnt, stp);
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [PEOPLE_W-1:0] cnt;
    logic [STEP_W-1:0] stp;
    pick = $urandom_range(31);
    // mostly short rings, a few medium ones, rarely an oversized count
    if (pick == 0) begin
      cnt = PEOPLE_W'($urandom_range(2047, 1025));
      stp = STEP_W'($urandom_range(3, 0));
    end else begin
      if (pick < 4) cnt = PEOPLE_W'($urandom_range(200, 64));
      else cnt = PEOPLE_W'($urandom_range(63, 0));
      pick = $urandom_range(3);
      if (pick == 0) stp = STEP_W'($urandom_range(9, 0));
      else if (pick == 1) stp = STEP_W'($urandom_range(65535, 0));
      else stp = STEP_W'($urandom_range(300, 1));
    end
    send_request(cnt, stp);
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 63;
    send_request(11'd1, 16'd1);
    send_request(11'd0, 16'd5);
    send_request(11'd0, 16'd0);
    send_request(11'd1, 16'd0);
    send_request(11'd2, 16'd1);
    send_request(11'd2, 16'd2);
    send_request(11'd7, 16'd3);
    send_request(11'd10, 16'd0);
    send_request(11'd10, 16'd1);
    send_request(11'd5, 16'd65535);
    send_request(11'd3, 16'd65534);
    send_request(11'd13, 16'd32768);
    send_request(11'd41, 16'd3);
    send_request(11'd100, 16'd7);
    send_request(11'd6, 16'd1024);
    send_request(11'd1024, 16'd2);
    send_request(11'd2047, 16'd1);
    send_request(11'd1025, 16'd3);
    send_request(11'd1023, 16'd0);
    send_request(11'd682, 16'd21845);
    repeat (40) send_random();

    send_idle_pct = 63;
    recv_idle_pct = 28;
    repeat (40) send_random();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (10)
      send_request(PEOPLE_W'($urandom_range(12, 2)), STEP_W'($urandom_range(20, 0)));
    repeat (30) send_random();
    in_valid <= 1'b0;

    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d survivors never arrived", board.pending()));

    $display("covered %0d requests: counts 0..2047 with saturation, steps 0..65535,",
             board.requests);
    $display("three handshake idle mixes and a long output stall; %0d survivors, %0d bad",
             board.survivors_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("josephus_survivor_top test passed");
    end else begin
      $display("josephus_survivor_top test failed");
    end
    $finish;
  end

endmodule
